FILE: rtl/core/srp_pkg.sv
// Shared types, constants and helper functions of the section record parser.
package srp_pkg;

    localparam int TAG_LENGTH = 10;
    localparam int MATCH_W    = 4;
    localparam int FIELD_W    = 2;

    localparam logic [7:0] CH_OPEN    = 8'h5B;
    localparam logic [7:0] CH_CLOSE   = 8'h5D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [31:0] MAX_X    = 32'h0000_FFFF;
    localparam logic [31:0] MAX_Y    = 32'h0000_FFFF;
    localparam logic [31:0] MAX_TIME = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_TYPE = 32'h0000_00FF;

    typedef enum logic [5:0] {
        PH_SEARCH = 6'b000001,
        PH_TAG    = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_START  = 6'b001000,
        PH_REC    = 6'b010000,
        PH_REST   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [31:0] hit_time;
        logic [7:0]  object_type;
        logic        truncated;
    } t_out_item;

    function automatic logic [7:0] tag_char(input logic [MATCH_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h69;
            4'd2:    c = 8'h74;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h62;
            4'd5:    c = 8'h6A;
            4'd6:    c = 8'h65;
            4'd7:    c = 8'h63;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] sat_mac(input logic [31:0] acc,
                                            input logic [3:0]  digit,
                                            input logic [31:0] maxv);
        logic [35:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + 36'(digit);
        return (v > 36'(maxv)) ? maxv : v[31:0];
    endfunction

endpackage

FILE: rtl/core/srp_stream_if.sv
// Valid/ready stream interfaces for the input bytes and the output records.
interface srp_in_if;
    logic               valid;
    logic               ready;
    srp_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface srp_out_if;
    logic               valid;
    logic               ready;
    srp_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/section_record_parser.sv
// Section record parser: finds the section tag and turns each later line into a record.
//
//   channel   direction  transfer when          payload
//   i_in      sink       valid && ready         data_byte[8], final_byte[1]
//   o_out     source     valid && ready         x_coord[16], y_coord[16], hit_time[32],
//                                               object_type[8], truncated[1]
//
// One byte per cycle sustained unless the output stalls.
// Input register, combinational parse logic with the saturating multiply-add, result register.
// Reset (i_rst_n low, synchronous) returns to the tag search with empty accumulators.
// A stalled output holds the parse stage; the input register still takes a byte when empty.
module section_record_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srp_in_if.sink            i_in,
    srp_out_if.source         o_out
);

    logic                          r_in_valid;
    srp_pkg::t_in_item             r_in_item;
    logic                          r_out_valid;
    srp_pkg::t_out_item            r_out_item;

    srp_pkg::t_phase               r_phase, n_phase;
    logic [srp_pkg::MATCH_W-1:0]   r_match, n_match;
    logic [srp_pkg::FIELD_W-1:0]   r_field, n_field;
    logic [15:0]                   r_acc_x, n_acc_x;
    logic [15:0]                   r_acc_y, n_acc_y;
    logic [31:0]                   r_acc_time, n_acc_time;
    logic [7:0]                    r_acc_type, n_acc_type;

    logic                          proc_go;
    logic                          emit;
    srp_pkg::t_out_item            emit_item;
    logic [7:0]                    cur_byte;
    logic                          is_digit;
    logic [3:0]                    digit;

    assign proc_go     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || proc_go;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out_item;

    assign cur_byte = r_in_item.data_byte;
    assign is_digit = (cur_byte >= srp_pkg::CH_ZERO) && (cur_byte <= srp_pkg::CH_NINE);
    assign digit    = 4'(cur_byte - srp_pkg::CH_ZERO);

    always_comb begin
        n_phase    = r_phase;
        n_match    = r_match;
        n_field    = r_field;
        n_acc_x    = r_acc_x;
        n_acc_y    = r_acc_y;
        n_acc_time = r_acc_time;
        n_acc_type = r_acc_type;
        emit       = 1'b0;
        emit_item  = '{x_coord: r_acc_x, y_coord: r_acc_y, hit_time: r_acc_time,
                       object_type: r_acc_type, truncated: 1'b0};

        unique case (r_phase)
            srp_pkg::PH_TAG: begin
                if (r_match < srp_pkg::MATCH_W'(srp_pkg::TAG_LENGTH)) begin
                    if (cur_byte == srp_pkg::tag_char(r_match)) begin
                        n_match = r_match + 1'b1;
                    end else begin
                        n_match = '0;
                        n_phase = (cur_byte == srp_pkg::CH_OPEN) ? srp_pkg::PH_TAG
                                                                 : srp_pkg::PH_SEARCH;
                    end
                end else if (cur_byte == srp_pkg::CH_CLOSE) begin
                    n_phase = srp_pkg::PH_SKIP;
                    n_match = '0;
                end else begin
                    n_match = '0;
                    n_phase = (cur_byte == srp_pkg::CH_OPEN) ? srp_pkg::PH_TAG
                                                             : srp_pkg::PH_SEARCH;
                end
            end
            srp_pkg::PH_SKIP: begin
                if (r_match != '0) begin
                    n_phase = srp_pkg::PH_START;
                    n_match = '0;
                end else begin
                    n_match = srp_pkg::MATCH_W'(1);
                end
            end
            srp_pkg::PH_START, srp_pkg::PH_REC: begin
                if (is_digit) begin
                    unique case (r_field)
                        2'd0: n_acc_x = 16'(srp_pkg::sat_mac(32'(r_acc_x), digit,
                                                             srp_pkg::MAX_X));
                        2'd1: n_acc_y = 16'(srp_pkg::sat_mac(32'(r_acc_y), digit,
                                                             srp_pkg::MAX_Y));
                        2'd2: n_acc_time = srp_pkg::sat_mac(r_acc_time, digit,
                                                            srp_pkg::MAX_TIME);
                        default: n_acc_type = 8'(srp_pkg::sat_mac(32'(r_acc_type), digit,
                                                                  srp_pkg::MAX_TYPE));
                    endcase
                    n_phase = srp_pkg::PH_REC;
                end else if (r_field != 2'd3) begin
                    n_field = r_field + 1'b1;
                    n_phase = srp_pkg::PH_REC;
                end else begin
                    emit       = 1'b1;
                    n_field    = '0;
                    n_acc_x    = '0;
                    n_acc_y    = '0;
                    n_acc_time = '0;
                    n_acc_type = '0;
                    n_phase    = (cur_byte == srp_pkg::CH_NEWLINE) ? srp_pkg::PH_START
                                                                   : srp_pkg::PH_REST;
                end
            end
            srp_pkg::PH_REST: begin
                if (cur_byte == srp_pkg::CH_NEWLINE) begin
                    n_phase = srp_pkg::PH_START;
                end
            end
            default: begin
                if (cur_byte == srp_pkg::CH_OPEN) begin
                    n_phase = srp_pkg::PH_TAG;
                    n_match = '0;
                end else begin
                    n_phase = srp_pkg::PH_SEARCH;
                end
            end
        endcase

        if (r_in_item.final_byte) begin
            if (!emit && (n_phase == srp_pkg::PH_REC)) begin
                emit      = 1'b1;
                emit_item = '{x_coord: n_acc_x, y_coord: n_acc_y, hit_time: n_acc_time,
                              object_type: n_acc_type, truncated: 1'b1};
            end
            n_phase    = srp_pkg::PH_SEARCH;
            n_match    = '0;
            n_field    = '0;
            n_acc_x    = '0;
            n_acc_y    = '0;
            n_acc_time = '0;
            n_acc_type = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_in_item <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= srp_pkg::PH_SEARCH;
            r_match    <= '0;
            r_field    <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
            r_acc_time <= '0;
            r_acc_type <= '0;
        end else if (proc_go) begin
            r_phase    <= n_phase;
            r_match    <= n_match;
            r_field    <= n_field;
            r_acc_x    <= n_acc_x;
            r_acc_y    <= n_acc_y;
            r_acc_time <= n_acc_time;
            r_acc_type <= n_acc_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && emit) begin
            r_out_item <= emit_item;
        end
    end

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parse phase is not one-hot");

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && r_in_item.final_byte |=> r_phase == srp_pkg::PH_SEARCH && r_field == '0)
        else $error("final byte did not return the parser to the tag search");

    a_search_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == srp_pkg::PH_SEARCH |-> r_acc_x == '0 && r_acc_y == '0 &&
                                          r_acc_time == '0 && r_acc_type == '0)
        else $error("accumulators not clear during tag search");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == srp_pkg::PH_TAG |-> r_match <= srp_pkg::MATCH_W'(srp_pkg::TAG_LENGTH))
        else $error("tag match position ran past the tag length");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc_go |=> $stable(r_phase) && $stable(r_field) && r_in_valid)
        else $error("parse state moved while the result register was stalled");

    a_full_record_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && emit && !emit_item.truncated |=> r_field == '0 && r_acc_x == '0)
        else $error("record not cleared after a complete record");

endmodule
